>>> src/vmvp_pkg.sv
package vmvp_pkg;

	localparam int COEF_W = 16;
	localparam int PROD_W = 48;
	localparam int ACC_W = 50;
	localparam int CLIP_W = 42;
	localparam int QUO_W = 36;
	localparam int NDC_W = 38;
	localparam int SCR_W = 56;
	localparam int DIV_STAGES = 36;
	localparam int MAT_LATENCY = 2;
	localparam int DIV_LATENCY = DIV_STAGES + 1;
	localparam int VP_LATENCY = 3;
	localparam int SIDE_STAGES = MAT_LATENCY + DIV_LATENCY;
	localparam int LATENCY = SIDE_STAGES + VP_LATENCY;

	typedef enum logic [2:0] {
		REG_ROW0      = 3'd0,
		REG_ROW1      = 3'd1,
		REG_ROW2      = 3'd2,
		REG_ROW3      = 3'd3,
		REG_VP_WIDTH  = 3'd4,
		REG_VP_HEIGHT = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] pos_w;
	} vertex_t;

	typedef struct packed {
		logic signed [31:0] screen_x;
		logic signed [31:0] screen_y;
		logic signed [31:0] depth;
		logic signed [31:0] normal_x;
		logic signed [31:0] normal_y;
		logic signed [31:0] normal_z;
		logic               divide_fault;
	} result_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} normal_t;

	typedef struct packed {
		logic              neg;
		logic              ovf;
		logic              zero;
		logic [QUO_W-1:0]  quo;
	} div_res_t;

	function automatic logic [31:0] sat32(input logic signed [SCR_W-1:0] v);
		logic [31:0] r;
		if ((&v[SCR_W-1:31]) || !(|v[SCR_W-1:31]))
			r = v[31:0];
		else if (v[SCR_W-1])
			r = 32'h8000_0000;
		else
			r = 32'h7fff_ffff;
		return r;
	endfunction

endpackage

>>> src/vmvp_matmul.sv
module vmvp_matmul (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  vmvp_pkg::vertex_t                    vertex,
	input  logic [63:0]                          row [4],
	output logic                                 out_valid,
	output logic signed [vmvp_pkg::CLIP_W-1:0]   clip [4]
);

	logic                                 valid_s1;
	logic                                 valid_s2;
	logic signed [vmvp_pkg::PROD_W-1:0]   prod_s1 [4][4];
	logic signed [vmvp_pkg::CLIP_W-1:0]   clip_s2 [4];
	logic signed [31:0]                   pos_c [4];
	logic signed [vmvp_pkg::ACC_W-1:0]    acc_c [4];

	assign pos_c[0] = vertex.pos_x;
	assign pos_c[1] = vertex.pos_y;
	assign pos_c[2] = vertex.pos_z;
	assign pos_c[3] = vertex.pos_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	// one 16x32 product per coefficient
	always_ff @(posedge clk) begin
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				prod_s1[r][c] <= $signed(row[r][16*c +: vmvp_pkg::COEF_W]) * pos_c[c];
			end
		end
	end

	always_comb begin
		for (int r = 0; r < 4; r++) begin
			acc_c[r] = vmvp_pkg::ACC_W'(prod_s1[r][0]) + vmvp_pkg::ACC_W'(prod_s1[r][1])
				+ vmvp_pkg::ACC_W'(prod_s1[r][2]) + vmvp_pkg::ACC_W'(prod_s1[r][3]);
		end
	end

	// drop 8 fraction bits with floor
	always_ff @(posedge clk) begin
		for (int r = 0; r < 4; r++) begin
			clip_s2[r] <= acc_c[r][vmvp_pkg::ACC_W-1:8];
		end
	end

	assign out_valid = valid_s2;
	assign clip = clip_s2;

endmodule

>>> src/vmvp_divider.sv
module vmvp_divider (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic signed [vmvp_pkg::CLIP_W-1:0]  num,
	input  logic signed [vmvp_pkg::CLIP_W-1:0]  den,
	output logic                                out_valid,
	output vmvp_pkg::div_res_t                  res
);

	localparam int N = vmvp_pkg::DIV_STAGES;
	localparam int W = vmvp_pkg::CLIP_W;
	localparam int Q = vmvp_pkg::QUO_W;

	logic [W-1:0]  nabs_c;
	logic [W-1:0]  dabs_c;
	logic          valid_s [N+1];
	logic [W-1:0]  rem_s [N+1];
	logic [Q-1:0]  nq_s [N+1];
	logic [W-1:0]  dabs_s [N+1];
	logic          neg_s [N+1];
	logic          ovf_s [N+1];
	logic          zero_s [N+1];
	logic [W+1:0]  trial_c [N];

	assign nabs_c = num[W-1] ? W'(-num) : W'(num);
	assign dabs_c = den[W-1] ? W'(-den) : W'(den);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= N; k++) valid_s[k] <= 1'b0;
		end else begin
			valid_s[0] <= in_valid;
			for (int k = 0; k < N; k++) valid_s[k+1] <= valid_s[k];
		end
	end

	always_comb begin
		for (int k = 0; k < N; k++) begin
			trial_c[k] = {1'b0, rem_s[k], nq_s[k][Q-1]} - {2'b00, dabs_s[k]};
		end
	end

	// restoring division on magnitudes, one quotient bit per stage
	always_ff @(posedge clk) begin
		rem_s[0]  <= {20'd0, nabs_c[W-1:20]};
		nq_s[0]   <= {nabs_c[19:0], 16'd0};
		dabs_s[0] <= dabs_c;
		neg_s[0]  <= num[W-1] ^ den[W-1];
		ovf_s[0]  <= {20'd0, nabs_c[W-1:20]} >= dabs_c;
		zero_s[0] <= (den == '0);
		for (int k = 0; k < N; k++) begin
			if (!trial_c[k][W+1]) begin
				rem_s[k+1] <= trial_c[k][W-1:0];
				nq_s[k+1]  <= {nq_s[k][Q-2:0], 1'b1};
			end else begin
				rem_s[k+1] <= {rem_s[k][W-2:0], nq_s[k][Q-1]};
				nq_s[k+1]  <= {nq_s[k][Q-2:0], 1'b0};
			end
			dabs_s[k+1] <= dabs_s[k];
			neg_s[k+1]  <= neg_s[k];
			ovf_s[k+1]  <= ovf_s[k];
			zero_s[k+1] <= zero_s[k];
		end
	end

	assign out_valid = valid_s[N];
	assign res.neg   = neg_s[N];
	assign res.ovf   = ovf_s[N];
	assign res.zero  = zero_s[N];
	assign res.quo   = nq_s[N];

endmodule

>>> src/vmvp_viewport.sv
module vmvp_viewport (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  vmvp_pkg::div_res_t  div_x,
	input  vmvp_pkg::div_res_t  div_y,
	input  vmvp_pkg::div_res_t  div_z,
	input  vmvp_pkg::normal_t   normal,
	input  logic [15:0]         vp_width,
	input  logic [15:0]         vp_height,
	output logic                done,
	output vmvp_pkg::result_t   result
);

	localparam int NW = vmvp_pkg::NDC_W;
	localparam int SW = vmvp_pkg::SCR_W;

	logic                  valid_s1, valid_s2, valid_s3;
	logic                  fault_s1, fault_s2;
	logic signed [NW:0]    bx_s1, by_s1;
	logic [31:0]           depth_s1, depth_s2;
	logic signed [SW-1:0]  tx_s2, ty_s2;
	vmvp_pkg::normal_t     normal_s1, normal_s2;
	vmvp_pkg::result_t     result_s3;
	logic signed [NW-1:0]  ndc_x_c, ndc_y_c, ndc_z_c;
	logic signed [SW-1:0]  hx_c, hy_c;

	function automatic logic signed [NW-1:0] to_ndc(input vmvp_pkg::div_res_t d);
		logic [NW-1:0] mag;
		mag = d.ovf ? (NW'(1) << vmvp_pkg::QUO_W) : NW'(d.quo);
		return d.neg ? -$signed(mag) : $signed(mag);
	endfunction

	assign ndc_x_c = to_ndc(div_x);
	assign ndc_y_c = to_ndc(div_y);
	assign ndc_z_c = to_ndc(div_z);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// ndc + 1.0, depth saturation
	always_ff @(posedge clk) begin
		bx_s1     <= (NW+1)'(ndc_x_c) + (NW+1)'(65536);
		by_s1     <= (NW+1)'(ndc_y_c) + (NW+1)'(65536);
		depth_s1  <= vmvp_pkg::sat32(SW'(ndc_z_c));
		fault_s1  <= div_x.zero;
		normal_s1 <= normal;
	end

	// scale by viewport size
	always_ff @(posedge clk) begin
		tx_s2     <= SW'(bx_s1 * $signed({1'b0, vp_width}));
		ty_s2     <= SW'(by_s1 * $signed({1'b0, vp_height}));
		depth_s2  <= depth_s1;
		fault_s2  <= fault_s1;
		normal_s2 <= normal_s1;
	end

	// halve toward zero
	assign hx_c = $signed(tx_s2 + SW'(tx_s2[SW-1])) >>> 1;
	assign hy_c = $signed(ty_s2 + SW'(ty_s2[SW-1])) >>> 1;

	always_ff @(posedge clk) begin
		result_s3.screen_x     <= fault_s2 ? '0 : vmvp_pkg::sat32(hx_c);
		result_s3.screen_y     <= fault_s2 ? '0 : vmvp_pkg::sat32(hy_c);
		result_s3.depth        <= fault_s2 ? '0 : depth_s2;
		result_s3.normal_x     <= normal_s2.x;
		result_s3.normal_y     <= normal_s2.y;
		result_s3.normal_z     <= normal_s2.z;
		result_s3.divide_fault <= fault_s2;
	end

	assign done = valid_s3;
	assign result = result_s3;

endmodule

>>> src/vertex_mvp_viewport_transform.sv
// Vertex transform: 4x4 MVP multiply, perspective divide and viewport mapping.
// One vertex is taken every clock cycle (busy is never raised) and each result
// passes through the multiply stages, the 36-stage divider pipeline and the
// viewport stages. done pulses for one cycle and the receiver cannot stall, so
// results must be captured when done is high. The user must write configuration
// only while no vertex is in flight; the block does not enforce this.
module vertex_mvp_viewport_transform (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  vmvp_pkg::vertex_t   vertex,
	output logic                done,
	output vmvp_pkg::result_t   result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [63:0]         cfg_data
);

	localparam int S = vmvp_pkg::SIDE_STAGES;

	logic [63:0]                         row_q [4];
	logic [15:0]                         vp_width_q;
	logic [15:0]                         vp_height_q;
	logic                                accept;
	logic                                mat_valid;
	logic signed [vmvp_pkg::CLIP_W-1:0]  clip [4];
	logic                                div_valid_x, div_valid_y, div_valid_z;
	vmvp_pkg::div_res_t                  div_x, div_y, div_z;
	vmvp_pkg::normal_t                   side_s [S];

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 4; r++) row_q[r] <= '0;
			vp_width_q  <= 16'd640;
			vp_height_q <= 16'd480;
		end else if (cfg_valid && cfg_ready) begin
			unique case (vmvp_pkg::cfg_reg_t'(cfg_index))
				vmvp_pkg::REG_ROW0:      row_q[0] <= cfg_data;
				vmvp_pkg::REG_ROW1:      row_q[1] <= cfg_data;
				vmvp_pkg::REG_ROW2:      row_q[2] <= cfg_data;
				vmvp_pkg::REG_ROW3:      row_q[3] <= cfg_data;
				vmvp_pkg::REG_VP_WIDTH:  vp_width_q <= cfg_data[15:0];
				vmvp_pkg::REG_VP_HEIGHT: vp_height_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// normals ride alongside the maths
	always_ff @(posedge clk) begin
		side_s[0] <= '{x: vertex.pos_x, y: vertex.pos_y, z: vertex.pos_z};
		for (int k = 1; k < S; k++) side_s[k] <= side_s[k-1];
	end

	vmvp_matmul u_matmul (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.vertex    (vertex),
		.row       (row_q),
		.out_valid (mat_valid),
		.clip      (clip)
	);

	vmvp_divider u_div_x (
		.clk (clk), .arst_n (arst_n), .in_valid (mat_valid),
		.num (clip[0]), .den (clip[3]), .out_valid (div_valid_x), .res (div_x)
	);

	vmvp_divider u_div_y (
		.clk (clk), .arst_n (arst_n), .in_valid (mat_valid),
		.num (clip[1]), .den (clip[3]), .out_valid (div_valid_y), .res (div_y)
	);

	vmvp_divider u_div_z (
		.clk (clk), .arst_n (arst_n), .in_valid (mat_valid),
		.num (clip[2]), .den (clip[3]), .out_valid (div_valid_z), .res (div_z)
	);

	vmvp_viewport u_viewport (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (div_valid_x),
		.div_x     (div_x),
		.div_y     (div_y),
		.div_z     (div_z),
		.normal    (side_s[S-1]),
		.vp_width  (vp_width_q),
		.vp_height (vp_height_q),
		.done      (done),
		.result    (result)
	);

	a_div_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		div_valid_x == div_valid_y && div_valid_x == div_valid_z)
		else $error("divider lanes out of step");

	a_fixed_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##(vmvp_pkg::LATENCY) done)
		else $error("transfer not delivered at fixed latency");

	a_fault_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.divide_fault |->
		result.screen_x == '0 && result.screen_y == '0 && result.depth == '0)
		else $error("fault result not zeroed");

	a_normal_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.normal_x == $past(vertex.pos_x, vmvp_pkg::LATENCY))
		else $error("normal out of step with vertex");

endmodule

>>> tb/vmvp_checker.sv
`timescale 1ns / 100ps

module vmvp_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  vmvp_pkg::vertex_t   vertex,
	input  logic                done,
	input  vmvp_pkg::result_t   result,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [63:0]         cfg_data,
	output int                  fail_count,
	output int                  pending,
	output int                  results_seen,
	output int                  faults_seen
);
	import vmvp_pkg::*;

	logic [63:0] mat_row [4];
	logic [15:0] vp_w, vp_h;
	result_t     expected_q [$];

	function automatic logic signed [31:0] clamp32(input longint v);
		if (v > 64'sd2147483647)
			return 32'h7fff_ffff;
		if (v < -64'sd2147483648)
			return 32'h8000_0000;
		return v[31:0];
	endfunction

	function automatic result_t project_vertex(input vertex_t v);
		result_t r;
		longint p [4];
		longint clip [4];
		longint acc, m, q, ndc [3];
		p[0] = longint'(v.pos_x);
		p[1] = longint'(v.pos_y);
		p[2] = longint'(v.pos_z);
		p[3] = longint'(v.pos_w);
		for (int i = 0; i < 4; i++) begin
			acc = 0;
			for (int c = 0; c < 4; c++) begin
				m = longint'($signed(mat_row[i][16*c +: 16]));
				acc += m * p[c];
			end
			clip[i] = acc >>> 8;
		end
		r = '0;
		r.normal_x = v.pos_x;
		r.normal_y = v.pos_y;
		r.normal_z = v.pos_z;
		if (clip[3] == 0) begin
			r.divide_fault = 1'b1;
			return r;
		end
		for (int i = 0; i < 3; i++) begin
			q = (clip[i] * 65536) / clip[3];
			if (q > (64'sd1 <<< 40))
				q = 64'sd1 <<< 40;
			if (q < -(64'sd1 <<< 40))
				q = -(64'sd1 <<< 40);
			ndc[i] = q;
		end
		r.screen_x = clamp32(((ndc[0] + 65536) * longint'({48'd0, vp_w})) / 2);
		r.screen_y = clamp32(((ndc[1] + 65536) * longint'({48'd0, vp_h})) / 2);
		r.depth = clamp32(ndc[2]);
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		result_t e;
		if (!arst_n) begin
			for (int i = 0; i < 4; i++)
				mat_row[i] <= '0;
			vp_w <= 16'd640;
			vp_h <= 16'd480;
			fail_count <= 0;
			results_seen <= 0;
			faults_seen <= 0;
			expected_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_ROW0, REG_ROW1, REG_ROW2, REG_ROW3: mat_row[cfg_index[1:0]] <= cfg_data;
					REG_VP_WIDTH: vp_w <= cfg_data[15:0];
					REG_VP_HEIGHT: vp_h <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (done) begin
				results_seen <= results_seen + 1;
				if (result.divide_fault)
					faults_seen <= faults_seen + 1;
				if (expected_q.size() == 0) begin
					fail_count <= fail_count + 1;
					if (fail_count < 10)
						$display("unexpected result transfer %h", result);
				end else begin
					e = expected_q.pop_front();
					if (result !== e) begin
						fail_count <= fail_count + 1;
						if (fail_count < 10) begin
							$display("mismatch: expected sx=%h sy=%h d=%h n=%h/%h/%h f=%b",
								e.screen_x, e.screen_y, e.depth, e.normal_x, e.normal_y,
								e.normal_z, e.divide_fault);
							$display("          actual   sx=%h sy=%h d=%h n=%h/%h/%h f=%b",
								result.screen_x, result.screen_y, result.depth,
								result.normal_x, result.normal_y, result.normal_z,
								result.divide_fault);
						end
					end
				end
			end
			if (start && !busy)
				expected_q.push_back(project_vertex(vertex));
		end
	end

	assign pending = expected_q.size();

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import vmvp_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	vertex_t     vertex = '0;
	logic        done;
	result_t     result;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [63:0] cfg_data = '0;
	int          fail_count, pending, results_seen, faults_seen;
	int          vertices_sent = 0;
	int          configs_done = 0;
	int          stall_cycles = 0;
	logic        timed_out = 1'b0;

	localparam int WATCHDOG = 20000;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	vertex_mvp_viewport_transform u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .vertex(vertex),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	vmvp_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .vertex(vertex),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .fail_count(fail_count),
		.pending(pending), .results_seen(results_seen), .faults_seen(faults_seen)
	);

	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		wait (stall_cycles >= WATCHDOG);
		timed_out = 1'b1;
		$display("watchdog expired with %0d results outstanding", pending);
		$display("** vertex_mvp_viewport_transform: FAILED **");
		$finish;
	end

	function automatic logic [31:0] rand_coord(input int kind);
		case (kind)
			0: return $urandom();
			1: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
			2: return 32'($signed($urandom_range(0, 512)) - 256);
			default: return $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7fff_ffff;
		endcase
	endfunction

	task automatic write_reg(input cfg_reg_t idx, input logic [63:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		configs_done++;
	endtask

	task automatic drain();
		while (pending != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic send_vertex(input vertex_t v, input bit allow_gap);
		if (allow_gap && $urandom_range(0, 7) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		start <= 1'b1;
		vertex <= v;
		do @(posedge clk); while (busy);
		vertices_sent++;
	endtask

	task automatic end_burst();
		start <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [15:0] rand_coef();
		case ($urandom_range(0, 3))
			0: return 16'($urandom());
			1: return 16'($signed($urandom_range(0, 1024)) - 512);
			2: return $urandom_range(0, 1) ? 16'h0100 : 16'h0000;
			default: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
		endcase
	endfunction

	task automatic random_matrix();
		for (int i = 0; i < 4; i++)
			write_reg(cfg_reg_t'(i), {rand_coef(), rand_coef(), rand_coef(), rand_coef()});
	endtask

	task automatic random_phase(input int count, input bit gaps);
		vertex_t v;
		int kind;
		for (int i = 0; i < count; i++) begin
			kind = $urandom_range(0, 9) < 6 ? 1 : $urandom_range(0, 3);
			v.pos_x = rand_coord(kind);
			v.pos_y = rand_coord(kind);
			v.pos_z = rand_coord(kind);
			v.pos_w = $urandom_range(0, 9) == 0 ? 32'd0 :
				($urandom_range(0, 1) ? 32'h0001_0000 : rand_coord(kind));
			send_vertex(v, gaps);
		end
		end_burst();
	endtask

	initial begin
		vertex_t v;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity matrix, default viewport
		write_reg(REG_ROW0, 64'h0000_0000_0000_0100);
		write_reg(REG_ROW1, 64'h0000_0000_0100_0000);
		write_reg(REG_ROW2, 64'h0000_0100_0000_0000);
		write_reg(REG_ROW3, 64'h0100_0000_0000_0000);
		v = '{32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 32'h0001_0000};
		send_vertex(v, 0);
		v = '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001};
		send_vertex(v, 0);
		v = '{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff};
		send_vertex(v, 0);
		v = '{32'h1234_5678, 32'hdead_beef, 32'h0, 32'h0};
		send_vertex(v, 0);
		v = '{32'h0, 32'h0, 32'h0, 32'h8000_0000};
		send_vertex(v, 0);
		v = '{32'hffff_ffff, 32'h0000_0001, 32'hffff_0000, 32'h7fff_ffff};
		send_vertex(v, 0);
		end_burst();
		drain();

		// extreme coefficients and viewport sizes
		write_reg(REG_ROW0, 64'h7fff_8000_7fff_8000);
		write_reg(REG_ROW1, 64'h8000_7fff_8000_7fff);
		write_reg(REG_ROW2, 64'hffff_ffff_ffff_ffff);
		write_reg(REG_ROW3, 64'h0000_0000_0000_0001);
		write_reg(REG_VP_WIDTH, 64'hffff);
		write_reg(REG_VP_HEIGHT, 64'h1);
		v = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
		send_vertex(v, 0);
		v = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
		send_vertex(v, 0);
		v = '{32'h0, 32'h0, 32'h0, 32'h0000_0100};
		send_vertex(v, 0);
		v = '{32'h0, 32'h0, 32'h0, 32'h0000_00ff};
		send_vertex(v, 0);
		random_phase(8, 0);
		drain();

		// zero viewport size
		write_reg(REG_VP_WIDTH, 64'h0);
		write_reg(REG_VP_HEIGHT, 64'h0);
		write_reg(REG_ROW3, 64'h0100_0000_0000_0000);
		random_phase(5, 0);
		drain();

		for (int ph = 0; ph < 12; ph++) begin
			random_matrix();
			write_reg(REG_VP_WIDTH, {$urandom(), $urandom()});
			write_reg(REG_VP_HEIGHT, {$urandom(), $urandom()});
			random_phase(90, 1);
			drain();
		end

		// back to back, no idling
		write_reg(REG_VP_WIDTH, 64'd1920);
		write_reg(REG_VP_HEIGHT, 64'd1080);
		random_matrix();
		random_phase(150, 0);
		drain();

		$display("sent %0d vertices, %0d results (%0d divide faults), %0d register writes",
			vertices_sent, results_seen, faults_seen, configs_done);
		if (fail_count == 0 && !timed_out)
			$display("** vertex_mvp_viewport_transform: PASSED **");
		else
			$display("** vertex_mvp_viewport_transform: FAILED **");
		$finish;
	end

endmodule
